// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// expr must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

// ===== hw/rtl/wcg_pkg.sv =====
// ----------------------------------------------------------------------------
// Wavetable channel generator package
// Widths, register indexes, result struct and sample helpers.
// ----------------------------------------------------------------------------
package wcg_pkg;

   localparam int FREQ_W    = 11;
   localparam int VOL_W     = 2;
   localparam int WAVE_W    = 64;
   localparam int CYCLES_W  = 16;
   localparam int CTR_W     = 12;                 // period counter
   localparam int SUM_W     = CYCLES_W + 1;       // counter + cycle count
   localparam int PERIOD_W  = CTR_W + 1;          // period up to 4096
   localparam int POS_W     = 5;
   localparam int SAMPLE_W  = 4;
   localparam int CSR_IDX_W = 2;
   localparam int STEP_W    = $clog2(SUM_W);

   localparam logic [CSR_IDX_W-1:0] CSR_FREQ    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLUME  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAVE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WAVE_HI = 2'd3;

   localparam logic [VOL_W-1:0] VOL_MUTE    = 2'd0;
   localparam logic [VOL_W-1:0] VOL_FULL    = 2'd1;
   localparam logic [VOL_W-1:0] VOL_HALF    = 2'd2;
   localparam logic [VOL_W-1:0] VOL_QUARTER = 2'd3;

   localparam logic CMD_ADVANCE = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   typedef struct packed {
      logic                done;
      logic [POS_W-1:0]    quot_low;
      logic [CTR_W-1:0]    rem;
   } wcg_div_res_type;

   // nibble 0 is the top nibble of byte 0 (low word MSB)
   function automatic logic [SAMPLE_W-1:0] nibble_at(
      input logic [2*WAVE_W-1:0] table_bits,
      input logic [POS_W-1:0]    pos
   );
      logic [POS_W-1:0] idx;
      idx = ~pos;
      return table_bits[{idx, 2'b00} +: SAMPLE_W];
   endfunction

   function automatic logic [SAMPLE_W-1:0] apply_volume(
      input logic [VOL_W-1:0]    vol,
      input logic [SAMPLE_W-1:0] s
   );
      logic [SAMPLE_W-1:0] r;
      case (vol)
         VOL_MUTE: r = '0;
         VOL_FULL: r = s;
         VOL_HALF: r = s >> 1;
         default:  r = s >> 2;
      endcase
      return r;
   endfunction

endpackage

// ===== hw/rtl/wcg_ifs.sv =====
// ----------------------------------------------------------------------------
// Wavetable channel generator channel interfaces
// Step request channel and sample response channel, valid/ready.
// ----------------------------------------------------------------------------
interface wcg_req_if
   import wcg_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                cmd;
   logic [CYCLES_W-1:0] cycle_count;

   modport source (output valid, cmd, cycle_count, input ready);
   modport sink   (input valid, cmd, cycle_count, output ready);
endinterface

interface wcg_rsp_if
   import wcg_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample_out;
   logic [POS_W-1:0]    wave_position;

   modport source (output valid, sample_out, wave_position, input ready);
   modport sink   (input valid, sample_out, wave_position, output ready);
endinterface

// ===== hw/rtl/wavetable_channel_generator_unit.sv =====
// ----------------------------------------------------------------------------
// Wavetable channel generator
// Steps a 32-entry 4-bit wave table by elapsed machine cycles.
// ----------------------------------------------------------------------------
// Usage:
//   csr_* writes frequency, volume and the two packed wave words, idle only.
//   req_ch carries step beats: cmd advance adds cycle_count to the period
//   counter, cmd restart clears position and counter.
//   rsp_ch returns one beat per request: scaled sample and wave position.
// Sequencing:
//   An advance beat runs a one-bit-per-cycle restoring divider over the
//   17-bit counter sum in ST_DIV, then ST_FIN loads the output register; a
//   restart beat goes straight to ST_FIN. One request is in flight at a
//   time; req_ch.ready is high only while the sequencer is idle.
// Reset: registers return to frequency 0, volume full, wave table zero,
//   counter, position and last sample zero; no response is pending.
// Stall: the response sits in the output register until taken; a finished
//   division waits for that register before updating the channel state.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wavetable_channel_generator_unit
   import wcg_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WAVE_W-1:0]    csr_write_data,
   wcg_req_if.sink              req_ch,
   wcg_rsp_if.source            rsp_ch
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic                cmd_ff, cmd_in;
   logic [FREQ_W-1:0]   freq_ff;
   logic [VOL_W-1:0]    vol_ff;
   logic [WAVE_W-1:0]   wave_lo_ff, wave_hi_ff;
   logic [CTR_W-1:0]    ctr_ff, ctr_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [SAMPLE_W-1:0] last_ff, last_in;
   logic                out_valid_ff, out_valid_in;
   logic [SAMPLE_W-1:0] out_sample_ff, out_sample_in;
   logic [POS_W-1:0]    out_pos_ff, out_pos_in;

   logic                accept;
   logic                div_start;
   logic                load;
   logic [SUM_W-1:0]    sum;
   logic [PERIOD_W-1:0] period;
   logic [POS_W-1:0]    next_pos;
   logic [SAMPLE_W-1:0] next_sample;
   wcg_div_res_type     div_res;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign div_start    = accept && (req_ch.cmd == CMD_ADVANCE);

   // period = (2048 - frequency) * 2
   assign period = {(CTR_W'(1 << FREQ_W) - CTR_W'(freq_ff)), 1'b0};
   assign sum    = SUM_W'(ctr_ff) + SUM_W'(req_ch.cycle_count);

   wcg_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum),
      .divisor  (period),
      .res      (div_res)
   );

   assign load        = (state_ff == ST_FIN) && (!out_valid_ff || rsp_ch.ready);
   assign next_pos    = pos_ff + div_res.quot_low;
   assign next_sample = apply_volume(vol_ff, nibble_at({wave_lo_ff, wave_hi_ff}, next_pos));

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      ctr_in        = ctr_ff;
      pos_in        = pos_ff;
      last_in       = last_ff;
      out_sample_in = out_sample_ff;
      out_pos_in    = out_pos_ff;
      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in   = req_ch.cmd;
               state_in = (req_ch.cmd == CMD_ADVANCE) ? ST_DIV : ST_FIN;
            end
         end
         ST_DIV: begin
            if (div_res.done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (load) begin
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (cmd_ff == CMD_RESTART) begin
                  ctr_in        = '0;
                  pos_in        = '0;
                  out_sample_in = last_ff;
                  out_pos_in    = '0;
               end else begin
                  ctr_in        = div_res.rem;
                  pos_in        = next_pos;
                  last_in       = next_sample;
                  out_sample_in = next_sample;
                  out_pos_in    = next_pos;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmd_ff       <= CMD_ADVANCE;
         out_valid_ff <= 1'b0;
         ctr_ff       <= '0;
         pos_ff       <= '0;
         last_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         cmd_ff       <= cmd_in;
         out_valid_ff <= out_valid_in;
         ctr_ff       <= ctr_in;
         pos_ff       <= pos_in;
         last_ff      <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      out_sample_ff <= out_sample_in;
      out_pos_ff    <= out_pos_in;
   end

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff    <= '0;
         vol_ff     <= VOL_FULL;
         wave_lo_ff <= '0;
         wave_hi_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FREQ:    freq_ff    <= csr_write_data[FREQ_W-1:0];
            CSR_VOLUME:  vol_ff     <= csr_write_data[VOL_W-1:0];
            CSR_WAVE_LO: wave_lo_ff <= csr_write_data;
            CSR_WAVE_HI: wave_hi_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.sample_out    = out_sample_ff;
   assign rsp_ch.wave_position = out_pos_ff;

   `ASSERT_NEVER(a_done_outside_div, clock, reset, div_res.done && (state_ff != ST_DIV))
   `ASSERT_PROP(a_advance_enters_div, clock, reset, div_start |=> (state_ff == ST_DIV))
   `ASSERT_PROP(a_restart_zero_pos, clock, reset,
                (load && (cmd_ff == CMD_RESTART)) |=> (rsp_ch.wave_position == '0))
   `ASSERT_PROP(a_load_goes_idle, clock, reset, load |=> (rsp_ch.valid && req_ch.ready))

endmodule

// ===== hw/rtl/wcg_divider.sv =====
// ----------------------------------------------------------------------------
// Wavetable channel generator divider
// Radix-2 restoring divide of the counter sum by the period, one bit a cycle.
// ----------------------------------------------------------------------------
module wcg_divider
   import wcg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [SUM_W-1:0]    dividend,
   input  logic [PERIOD_W-1:0] divisor,
   output wcg_div_res_type     res
);

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   count_ff, count_in;
   logic [SUM_W-1:0]    dvd_ff, dvd_in;
   logic [PERIOD_W-1:0] dvs_ff, dvs_in;
   logic [CTR_W-1:0]    rem_ff, rem_in;
   logic [POS_W-1:0]    quot_ff, quot_in;

   logic [PERIOD_W-1:0] trial;
   logic                fits;

   // remainder stays below the period, so the shifted trial fits PERIOD_W bits
   assign trial = {rem_ff, dvd_ff[SUM_W-1]};
   assign fits  = (trial >= dvs_ff);

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      dvd_in   = dvd_ff;
      dvs_in   = dvs_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         dvd_in   = dividend;
         dvs_in   = divisor;
         rem_in   = '0;
         quot_in  = '0;
      end else if (busy_ff) begin
         dvd_in   = {dvd_ff[SUM_W-2:0], 1'b0};
         rem_in   = fits ? CTR_W'(trial - dvs_ff) : trial[CTR_W-1:0];
         quot_in  = {quot_ff[POS_W-2:0], fits};   // only low bits of quotient kept
         count_in = count_ff + 1'b1;
         if (count_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff  <= dvd_in;
      dvs_ff  <= dvs_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign res.done     = done_ff;
   assign res.quot_low = quot_ff;
   assign res.rem      = rem_ff;

endmodule

// ===== tb/wavetable_channel_generator_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wavetable channel generator testbench
// Directed and random step beats at random idle and stall patterns. A
// tracker keeps its own channel state and table and checks every sample
// beat in order.
// ----------------------------------------------------------------------------
module wavetable_channel_generator_unit_tb
   import wcg_pkg::*;
();

   localparam int DRAIN_CYCLES = 40;      // beyond the advance latency
   localparam int PHASE_ITEMS  = 100;
   localparam int PHASE_COUNT  = 12;

   typedef struct {
      logic [SAMPLE_W-1:0] sample;
      logic [POS_W-1:0]    position;
   } sample_beat_type;

   // Channel state, register copies and the queue of expected sample beats.
   class wave_step_tracker;
      logic [FREQ_W-1:0]   freq_code;
      logic [VOL_W-1:0]    vol_code;
      logic [WAVE_W-1:0]   wave_lo;
      logic [WAVE_W-1:0]   wave_hi;
      logic [CTR_W-1:0]    cycle_acc;
      logic [POS_W-1:0]    table_pos;
      logic [SAMPLE_W-1:0] held_sample;
      sample_beat_type     expected_beats[$];
      int                  mismatches;

      function new();
         freq_code   = '0;
         vol_code    = VOL_FULL;
         wave_lo     = '0;
         wave_hi     = '0;
         cycle_acc   = '0;
         table_pos   = '0;
         held_sample = '0;
         mismatches  = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [WAVE_W-1:0] data);
         case (idx)
            CSR_FREQ:    freq_code = data[FREQ_W-1:0];
            CSR_VOLUME:  vol_code  = data[VOL_W-1:0];
            CSR_WAVE_LO: wave_lo   = data;
            CSR_WAVE_HI: wave_hi   = data;
            default: ;
         endcase
      endfunction

      function int unsigned period_cycles();
         return (2048 - int'(freq_code)) * 2;
      endfunction

      function void note_step(logic cmd, logic [CYCLES_W-1:0] cycles);
         int unsigned         period;
         int unsigned         total;
         int unsigned         steps;
         logic [3:0]          byte_idx;
         logic [WAVE_W-1:0]   word;
         logic [7:0]          byte_val;
         logic [SAMPLE_W-1:0] raw;
         if (cmd == CMD_RESTART) begin
            cycle_acc = '0;
            table_pos = '0;
         end else begin
            period    = period_cycles();
            total     = int'(cycle_acc) + int'(cycles);
            steps     = total / period;
            cycle_acc = CTR_W'(total % period);
            // only the low bits of the quotient matter, position wraps at 32
            table_pos = table_pos + POS_W'(steps);
            byte_idx  = table_pos[POS_W-1:1];
            word      = byte_idx[3] ? wave_hi : wave_lo;
            byte_val  = 8'(word >> (56 - 8 * int'(byte_idx[2:0])));
            raw       = table_pos[0] ? byte_val[3:0] : byte_val[7:4];
            case (vol_code)
               VOL_MUTE: held_sample = '0;
               VOL_FULL: held_sample = raw;
               VOL_HALF: held_sample = raw >> 1;
               default:  held_sample = raw >> 2;
            endcase
         end
         expected_beats.push_back(sample_beat_type'{held_sample, table_pos});
      endfunction

      task report_mismatch(string what);
         if (mismatches < 40)
            $display("MISMATCH @%0t: %s", $realtime, what);
         mismatches++;
      endtask

      task check_sample(logic [SAMPLE_W-1:0] sample, logic [POS_W-1:0] position);
         sample_beat_type want;
         if (expected_beats.size() == 0) begin
            report_mismatch($sformatf("sample beat %0d pos %0d with nothing expected",
                                      sample, position));
         end else begin
            want = expected_beats.pop_front();
            if (sample !== want.sample)
               report_mismatch($sformatf("sample_out %0d, expected %0d", sample, want.sample));
            if (position !== want.position)
               report_mismatch($sformatf("wave_position %0d, expected %0d",
                                         position, want.position));
         end
      endtask
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [WAVE_W-1:0]    csr_write_data;

   wcg_req_if req_ch();
   wcg_rsp_if rsp_ch();

   wave_step_tracker tracker;
   logic [31:0]      ready_pattern = '1;
   int               gap_limit     = 0;
   int               burst_left    = 1;

   wavetable_channel_generator_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("wavetable_channel_generator_unit test failed");
      $finish;
   end

   // receiver: ready follows a rotating stall pattern set per phase
   initial begin : rsp_side
      int unsigned tick;
      tick         = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= ready_pattern[tick % 32];
         tick++;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         tracker.check_sample(rsp_ch.sample_out, rsp_ch.wave_position);
   end

   // sender idle: valid low, payload noise
   task automatic hold_off(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_ch.valid       <= 1'b0;
         req_ch.cmd         <= 1'($urandom);
         req_ch.cycle_count <= CYCLES_W'($urandom);
      end
   endtask

   task automatic send_step(logic cmd, logic [CYCLES_W-1:0] cycles);
      int gap;
      @(negedge clock);
      req_ch.valid       <= 1'b1;
      req_ch.cmd         <= cmd;
      req_ch.cycle_count <= cycles;
      do @(posedge clock); while (!req_ch.ready);
      tracker.note_step(cmd, cycles);
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(16, 1);
         gap        = $urandom_range(gap_limit, 0);
         if (gap > 0)
            hold_off(gap);
      end
   endtask

   task automatic wait_for_idle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (tracker.expected_beats.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [WAVE_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      tracker.write_register(idx, data);
   endtask

   task automatic load_settings(logic [FREQ_W-1:0] freq, logic [VOL_W-1:0] vol,
                                logic [WAVE_W-1:0] lo, logic [WAVE_W-1:0] hi);
      wait_for_idle();
      write_csr(CSR_FREQ, WAVE_W'(freq));
      write_csr(CSR_VOLUME, WAVE_W'(vol));
      write_csr(CSR_WAVE_LO, lo);
      write_csr(CSR_WAVE_HI, hi);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_phase(int items);
      logic [FREQ_W-1:0]   freq;
      logic [WAVE_W-1:0]   lo;
      logic [WAVE_W-1:0]   hi;
      int unsigned         span;
      logic                cmd;
      logic [CYCLES_W-1:0] cycles;
      case ($urandom_range(5, 0))
         0:       freq = '0;
         1:       freq = '1;
         2:       freq = FREQ_W'($urandom_range(2047, 1984));   // short periods
         default: freq = FREQ_W'($urandom);
      endcase
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      case ($urandom_range(7, 0))
         0: lo = '1;
         1: hi = '0;
         default: ;
      endcase
      case ($urandom_range(3, 0))
         0:       ready_pattern = '1;
         1:       ready_pattern = $urandom | 32'h1;
         2:       ready_pattern = ($urandom & $urandom & $urandom) | 32'h1;
         default: ready_pattern = 32'h0000_0001;
      endcase
      case ($urandom_range(2, 0))
         0:       gap_limit = 0;
         1:       gap_limit = 4;
         default: gap_limit = 40;
      endcase
      load_settings(freq, VOL_W'($urandom), lo, hi);
      repeat (items) begin
         span = tracker.period_cycles() * 3;
         if (span > 65535)
            span = 65535;
         cmd    = CMD_ADVANCE;
         cycles = CYCLES_W'($urandom);
         case ($urandom_range(9, 0))
            0:       cmd = CMD_RESTART;
            1:       cycles = $urandom_range(1, 0) ? '1 : '0;
            2, 3, 4: cycles = CYCLES_W'($urandom_range(span, 0));
            default: ;
         endcase
         send_step(cmd, cycles);
      end
   endtask

   initial begin
      reset              = 1'b1;
      csr_write_enable   = 1'b0;
      csr_index          = CSR_FREQ;
      csr_write_data     = '0;
      req_ch.valid       = 1'b0;
      req_ch.cmd         = CMD_ADVANCE;
      req_ch.cycle_count = '0;
      tracker            = new();
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // reset defaults: period 4096, empty table
      gap_limit = 3;
      send_step(CMD_ADVANCE, 16'd8192);
      send_step(CMD_RESTART, 16'd0);

      load_settings('0, VOL_FULL, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
      send_step(CMD_ADVANCE, 16'd0);
      send_step(CMD_ADVANCE, 16'd4095);
      send_step(CMD_ADVANCE, 16'd1);
      send_step(CMD_ADVANCE, 16'hFFFF);
      send_step(CMD_RESTART, 16'hFFFF);
      send_step(CMD_ADVANCE, 16'd4096);

      // shortest period; large quotient wraps the position
      load_settings('1, VOL_QUARTER, '1, 64'h5A5A_5A5A_A5A5_A5A5);
      send_step(CMD_ADVANCE, 16'hFFFF);
      send_step(CMD_ADVANCE, 16'd1);
      send_step(CMD_ADVANCE, 16'd3);
      send_step(CMD_RESTART, 16'd0);
      send_step(CMD_ADVANCE, 16'd2);

      // build up a large counter, then shrink the period under it
      load_settings('0, VOL_HALF, '1, '0);
      send_step(CMD_ADVANCE, 16'd4095);
      send_step(CMD_ADVANCE, 16'd4094);
      load_settings('1, VOL_MUTE, '1, '1);
      send_step(CMD_ADVANCE, 16'd0);
      send_step(CMD_ADVANCE, 16'hFFFF);

      load_settings(11'd1024, VOL_FULL, 64'hF0F0_F0F0_F0F0_F0F0, 64'h0F0F_0F0F_0F0F_0F0F);
      send_step(CMD_ADVANCE, 16'd2047);
      send_step(CMD_ADVANCE, 16'd1);
      send_step(CMD_ADVANCE, 16'(2048 * 17));

      repeat (PHASE_COUNT) random_phase(PHASE_ITEMS);

      wait_for_idle();
      if (tracker.mismatches == 0)
         $display("wavetable_channel_generator_unit test passed");
      else
         $display("wavetable_channel_generator_unit test failed");
      $finish;
   end

endmodule
